FILE: design/tms_dec_pkg.sv
package tms_dec_pkg;

  localparam int NUM_OPS = 73;

  // operand formats
  localparam logic [3:0] F_NONE    = 4'd0;
  localparam logic [3:0] F_CRU     = 4'd1;
  localparam logic [3:0] F_D       = 4'd2;
  localparam logic [3:0] F_DCNT    = 4'd3;
  localparam logic [3:0] F_DATA16  = 4'd4;
  localparam logic [3:0] F_DATA4   = 4'd5;
  localparam logic [3:0] F_DISP    = 4'd6;
  localparam logic [3:0] F_R       = 4'd7;
  localparam logic [3:0] F_RCNT    = 4'd8;
  localparam logic [3:0] F_RDATA16 = 4'd9;
  localparam logic [3:0] F_S       = 4'd10;
  localparam logic [3:0] F_SCNT    = 4'd11;
  localparam logic [3:0] F_SD      = 4'd12;
  localparam logic [3:0] F_SR      = 4'd13;

  // flag bits
  localparam logic [3:0] FL_LF   = 4'b0001;
  localparam logic [3:0] FL_REF  = 4'b0010;
  localparam logic [3:0] FL_CODE = 4'b0100;
  localparam logic [3:0] FL_RIP  = 4'b1000;
  localparam logic [3:0] FL_JMP  = FL_REF | FL_CODE;
  localparam logic [3:0] FL_BL   = FL_REF | FL_CODE | FL_LF;

  // addressing modes
  localparam logic [1:0] MODE_SYM = 2'd2;

  localparam logic [15:0] RIP_ZERO = 16'h0000;
  localparam logic [15:0] RIP_ONES = 16'hFFFF;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] match;
    logic [3:0]  fmt;
    logic [3:0]  fl;
  } op_entry_t;

  localparam op_entry_t OP_TABLE [NUM_OPS] = '{
    '{16'hFFF0, 16'h0080, F_R, 4'h0},       '{16'hFFF0, 16'h0090, F_R, 4'h0},
    '{16'hFFF0, 16'h0200, F_RDATA16, 4'h0}, '{16'hFFF0, 16'h0220, F_RDATA16, 4'h0},
    '{16'hFFF0, 16'h0240, F_RDATA16, 4'h0}, '{16'hFFF0, 16'h0260, F_RDATA16, 4'h0},
    '{16'hFFF0, 16'h0280, F_RDATA16, 4'h0}, '{16'hFFF0, 16'h02A0, F_R, 4'h0},
    '{16'hFFF0, 16'h02C0, F_R, 4'h0},       '{16'hFFFF, 16'h02E0, F_DATA16, 4'h0},
    '{16'hFFF0, 16'h0300, F_DATA4, 4'h0},   '{16'hFFFF, 16'h0340, F_NONE, 4'h0},
    '{16'hFFFF, 16'h0360, F_NONE, 4'h0},    '{16'hFFFF, 16'h0380, F_NONE, 4'h0},
    '{16'hFFFF, 16'h03A0, F_NONE, 4'h0},    '{16'hFFFF, 16'h03C0, F_NONE, 4'h0},
    '{16'hFFFF, 16'h03E0, F_NONE, 4'h0},
    '{16'hFFC0, 16'h0400, F_S, 4'h0},       '{16'hFFFF, 16'h045B, F_NONE, FL_LF},
    '{16'hFFC0, 16'h0440, F_S, FL_BL},      '{16'hFFC0, 16'h0480, F_S, 4'h0},
    '{16'hFFC0, 16'h04C0, F_D, 4'h0},       '{16'hFFC0, 16'h0500, F_D, 4'h0},
    '{16'hFFC0, 16'h0540, F_D, 4'h0},       '{16'hFFC0, 16'h0580, F_D, 4'h0},
    '{16'hFFC0, 16'h05C0, F_D, 4'h0},       '{16'hFFC0, 16'h0600, F_D, 4'h0},
    '{16'hFFC0, 16'h0640, F_D, 4'h0},       '{16'hFFC0, 16'h0680, F_D, FL_JMP},
    '{16'hFFC0, 16'h06C0, F_D, 4'h0},       '{16'hFFC0, 16'h0700, F_D, 4'h0},
    '{16'hFFC0, 16'h0740, F_D, 4'h0},
    '{16'hFF00, 16'h0800, F_RCNT, 4'h0},    '{16'hFF00, 16'h0900, F_RCNT, 4'h0},
    '{16'hFF00, 16'h0A00, F_RCNT, 4'h0},    '{16'hFF00, 16'h0B00, F_RCNT, 4'h0},
    '{16'hFFFF, 16'h1000, F_NONE, 4'h0},    '{16'hFF00, 16'h1000, F_DISP, FL_BL},
    '{16'hFF00, 16'h1100, F_DISP, FL_JMP},  '{16'hFF00, 16'h1200, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1300, F_DISP, FL_JMP},  '{16'hFF00, 16'h1400, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1500, F_DISP, FL_JMP},  '{16'hFF00, 16'h1600, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1700, F_DISP, FL_JMP},  '{16'hFF00, 16'h1800, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1900, F_DISP, FL_JMP},  '{16'hFF00, 16'h1A00, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1B00, F_DISP, FL_JMP},  '{16'hFF00, 16'h1C00, F_DISP, FL_JMP},
    '{16'hFF00, 16'h1D00, F_CRU, 4'h0},     '{16'hFF00, 16'h1E00, F_CRU, 4'h0},
    '{16'hFF00, 16'h1F00, F_CRU, 4'h0},
    '{16'hFC00, 16'h2000, F_SR, 4'h0},      '{16'hFC00, 16'h2400, F_SR, 4'h0},
    '{16'hFC00, 16'h2800, F_SR, 4'h0},      '{16'hFC00, 16'h2C00, F_SR, 4'h0},
    '{16'hFC00, 16'h3000, F_SCNT, 4'h0},    '{16'hFC00, 16'h3400, F_DCNT, 4'h0},
    '{16'hFC00, 16'h3800, F_SR, 4'h0},      '{16'hFC00, 16'h3C00, F_SR, 4'h0},
    '{16'hF000, 16'h4000, F_SD, 4'h0},      '{16'hF000, 16'h5000, F_SD, 4'h0},
    '{16'hF000, 16'h6000, F_SD, 4'h0},      '{16'hF000, 16'h7000, F_SD, 4'h0},
    '{16'hF000, 16'h8000, F_SD, 4'h0},      '{16'hF000, 16'h9000, F_SD, 4'h0},
    '{16'hF000, 16'hA000, F_SD, 4'h0},      '{16'hF000, 16'hB000, F_SD, 4'h0},
    '{16'hF000, 16'hC000, F_SD, 4'h0},      '{16'hF000, 16'hD000, F_SD, 4'h0},
    '{16'hF000, 16'hE000, F_SD, 4'h0},      '{16'hF000, 16'hF000, F_SD, 4'h0}
  };

endpackage

FILE: design/tms9900_instruction_decoder.sv
// Decodes one instruction per clock. An instruction is taken whenever start is high
// (busy is never raised) and is decoded from the input register in the next cycle.
// Its result is on the result ports with done high in the cycle after that.
// Every start beat gives exactly one result beat; done lasts one cycle and the
// receiver must take the beat then, as the block cannot hold it.
module tms9900_instruction_decoder
  import tms_dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        instr_addr,
  input  logic [15:0]        first_word,
  input  logic [15:0]        second_word,
  input  logic [15:0]        third_word,
  input  logic               addr_out_of_range,
  output logic               done,
  output logic               valid_res,
  output logic [6:0]         instr_index,
  output logic [3:0]         format,
  output logic [3:0]         src_reg,
  output logic [1:0]         src_mode,
  output logic [3:0]         dst_reg,
  output logic [1:0]         dst_mode,
  output logic signed [7:0]  small_value,
  output logic [15:0]        imm_value,
  output logic [2:0]         length_bytes,
  output logic [15:0]        ref_addr,
  output logic [3:0]         flags
);

  // input register
  logic        in_valid;
  logic [15:0] a_addr;
  logic [15:0] a_op;
  logic [15:0] a_ext0;
  logic [15:0] a_ext1;
  logic        a_oor;

  // decode
  logic        hit;
  logic [6:0]  idx;
  logic        ok;
  op_entry_t   ent;
  logic [1:0]  nxt;
  logic [15:0] dst_ext;
  logic [15:0] disp_off;
  logic        valid_res_next;
  logic [6:0]  instr_index_next;
  logic [3:0]  format_next;
  logic [3:0]  src_reg_next;
  logic [1:0]  src_mode_next;
  logic [3:0]  dst_reg_next;
  logic [1:0]  dst_mode_next;
  logic [7:0]  small_value_next;
  logic [15:0] imm_value_next;
  logic [2:0]  length_bytes_next;
  logic [15:0] ref_addr_next;
  logic [3:0]  flags_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      a_addr <= instr_addr;
      a_op   <= first_word;
      a_ext0 <= second_word;
      a_ext1 <= third_word;
      a_oor  <= addr_out_of_range;
    end
  end

  // first match wins: scan from the back so earlier entries override
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_OPS - 1; i >= 0; i--) begin
      if ((a_op & OP_TABLE[i].mask) == OP_TABLE[i].match) begin
        hit = 1'b1;
        idx = 7'(i);
      end
    end
  end

  assign ent      = OP_TABLE[idx];
  assign ok       = hit && !a_addr[0] && !a_oor;
  assign disp_off = {{8{a_op[7]}}, a_op[7:0]};

  always_comb begin
    nxt               = 2'd0;
    dst_ext           = a_ext0;
    valid_res_next    = 1'b0;
    instr_index_next  = '0;
    format_next       = F_NONE;
    src_reg_next      = '0;
    src_mode_next     = '0;
    dst_reg_next      = '0;
    dst_mode_next     = '0;
    small_value_next  = '0;
    imm_value_next    = '0;
    ref_addr_next     = '0;
    flags_next        = '0;
    if (ok) begin
      valid_res_next   = 1'b1;
      instr_index_next = idx;
      format_next      = ent.fmt;
      flags_next       = ent.fl;
      unique case (ent.fmt) inside
        F_D, F_S, F_DCNT, F_SCNT, F_SD, F_SR: begin
          src_reg_next  = a_op[3:0];
          src_mode_next = a_op[5:4];
          if (a_op[5:4] == MODE_SYM) begin
            nxt = 2'd1;
            if (a_op[3:0] == 4'd0) begin
              ref_addr_next = a_ext0;
              flags_next    = flags_next | FL_REF;
            end
          end
          if (ent.fmt == F_DCNT || ent.fmt == F_SCNT) begin
            small_value_next = {4'd0, a_op[9:6]};
          end
          if (ent.fmt == F_SR || ent.fmt == F_SD) begin
            dst_reg_next = a_op[9:6];
          end
          if (ent.fmt == F_SD) begin
            dst_mode_next = a_op[11:10];
            // destination takes the word after any source extension
            dst_ext = nxt[0] ? a_ext1 : a_ext0;
            if (a_op[11:10] == MODE_SYM) begin
              nxt = nxt + 2'd1;
              if (a_op[9:6] == 4'd0) begin
                ref_addr_next = dst_ext;
                flags_next    = flags_next | FL_REF;
              end
            end
          end
        end
        F_CRU: begin
          small_value_next = a_op[7:0];
        end
        F_DATA16, F_DATA4: begin
          imm_value_next = a_ext0;
          nxt            = 2'd1;
        end
        F_DISP: begin
          ref_addr_next = a_addr + 16'd2 + {disp_off[14:0], 1'b0};
          flags_next    = flags_next | FL_REF;
        end
        F_R: begin
          src_reg_next = a_op[3:0];
        end
        F_RCNT: begin
          src_reg_next     = a_op[3:0];
          small_value_next = {4'd0, a_op[7:4]};
        end
        F_RDATA16: begin
          src_reg_next   = a_op[3:0];
          imm_value_next = a_ext0;
          nxt            = 2'd1;
        end
        default: begin
        end
      endcase
    end
    length_bytes_next = ok ? (3'd2 + {nxt, 1'b0}) : 3'd0;
    // rip-stop holds for invalid words too
    if ((a_op == RIP_ZERO || a_op == RIP_ONES) && a_ext0 == a_op) begin
      flags_next = flags_next | FL_RIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      valid_res    <= valid_res_next;
      instr_index  <= instr_index_next;
      format       <= format_next;
      src_reg      <= src_reg_next;
      src_mode     <= src_mode_next;
      dst_reg      <= dst_reg_next;
      dst_mode     <= dst_mode_next;
      small_value  <= small_value_next;
      imm_value    <= imm_value_next;
      length_bytes <= length_bytes_next;
      ref_addr     <= ref_addr_next;
      flags        <= flags_next;
    end
  end

endmodule
